### src/qmr_pkg.sv
// ---------------------------------------------------------------------------
// qmr_pkg
// shared constants for the quaternion multiply and renormalise core
// ---------------------------------------------------------------------------
`default_nettype none

package qmr_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam int TOL_W         = 41;
    localparam int DATA_W        = 32;
    localparam int APB_DATA_W    = 64;
    localparam int APB_ADDR_W    = 4;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(64'h1_0000_0000);

    // register index as seen in paddr[3]
    localparam logic REG_TOL = 1'b0;

endpackage

`default_nettype wire

### src/qmr_sqrt.sv
// ---------------------------------------------------------------------------
// qmr_sqrt
// pipelined integer square root, one root bit per stage, rounded to nearest
// ---------------------------------------------------------------------------
`default_nettype none

module qmr_sqrt #(
    parameter int NW = 64
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [NW-1:0]     n_in,
    output logic      [NW/2:0]     root_out
);
    import qmr_pkg::*;

    localparam int H = NW / 2;

    logic [NW-1:0]  rem_reg  [H];
    logic [H-1:0]   root_reg [H];
    logic [H:0]     res_reg;

    genvar k;
    generate
        for (k = 0; k < H; k++)
        begin : g_stage
            localparam int B = H - 1 - k;
            logic [NW-1:0] prev_rem;
            logic [H-1:0]  prev_root;
            logic [NW:0]   trial;
            if (k == 0)
            begin : g_first
                assign prev_rem  = n_in;
                assign prev_root = '0;
            end
            else
            begin : g_next
                assign prev_rem  = rem_reg[k-1];
                assign prev_root = root_reg[k-1];
            end
            assign trial = ((NW+1)'(prev_root) << (B + 1)) | ((NW+1)'(1) << (2 * B));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if ({1'b0, prev_rem} >= trial)
                    begin
                        rem_reg[k]  <= NW'({1'b0, prev_rem} - trial);
                        root_reg[k] <= prev_root | (H'(1) << B);
                    end
                    else
                    begin
                        rem_reg[k]  <= prev_rem;
                        root_reg[k] <= prev_root;
                    end
                end
            end
        end
    endgenerate

    // round to nearest from the final remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rem_reg[H-1] > NW'(root_reg[H-1]))
                res_reg <= (H+1)'(root_reg[H-1]) + (H+1)'(1);
            else
                res_reg <= (H+1)'(root_reg[H-1]);
        end
    end

    assign root_out = res_reg;

endmodule

`default_nettype wire

### src/qmr_div.sv
// ---------------------------------------------------------------------------
// qmr_div
// pipelined restoring divider, one quotient bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module qmr_div #(
    parameter int NUMW = 62,
    parameter int DENW = 33
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [NUMW-1:0]   num,
    input  wire logic [DENW-1:0]   den,
    output logic      [NUMW-1:0]   quo
);
    import qmr_pkg::*;

    logic [NUMW-1:0] num_in_reg;
    logic [DENW-1:0] den_in_reg;

    logic [DENW-1:0] rem_reg [NUMW];
    logic [NUMW-1:0] quo_reg [NUMW];
    logic [NUMW-1:0] num_reg [NUMW];
    logic [DENW-1:0] den_reg [NUMW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_in_reg <= num;
            den_in_reg <= den;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NUMW; k++)
        begin : g_stage
            localparam int J = NUMW - 1 - k;
            logic [DENW-1:0] prev_rem;
            logic [NUMW-1:0] prev_quo;
            logic [NUMW-1:0] prev_num;
            logic [DENW-1:0] prev_den;
            logic [DENW:0]   shifted;
            if (k == 0)
            begin : g_first
                assign prev_rem = '0;
                assign prev_quo = '0;
                assign prev_num = num_in_reg;
                assign prev_den = den_in_reg;
            end
            else
            begin : g_next
                assign prev_rem = rem_reg[k-1];
                assign prev_quo = quo_reg[k-1];
                assign prev_num = num_reg[k-1];
                assign prev_den = den_reg[k-1];
            end
            assign shifted = {prev_rem, prev_num[J]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[k] <= prev_num;
                    den_reg[k] <= prev_den;
                    if (shifted >= {1'b0, prev_den})
                    begin
                        rem_reg[k] <= DENW'(shifted - {1'b0, prev_den});
                        quo_reg[k] <= prev_quo | (NUMW'(1) << J);
                    end
                    else
                    begin
                        rem_reg[k] <= DENW'(shifted);
                        quo_reg[k] <= prev_quo;
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[NUMW-1];

endmodule

`default_nettype wire

### src/quaternion_multiply_renormalise_core.sv
// ---------------------------------------------------------------------------
// quaternion_multiply_renormalise_core
// hamilton product of two quaternions with conditional renormalization
// ---------------------------------------------------------------------------
// Takes one request per clock and returns one result per clock for as long as
// the output side is ready; the pipeline depth is set by the bit-per-stage
// square root and the bit-per-stage dividers. A stall on the output freezes
// the whole pipeline, and input ready follows it. Components are signed fixed
// point with FRAC_BITS fraction bits, saturated to +-1.0; the product is
// divided by its rounded norm when the squared norm is off one by more than
// renorm_tolerance (units of 2^-60, APB register 0 at byte address 0). A zero
// norm is flagged.
`default_nettype none

module quaternion_multiply_renormalise_core #(
    parameter int FRAC_BITS = qmr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // apb
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [qmr_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [qmr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [qmr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    // request in
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
    input  wire logic [8*qmr_pkg::DATA_W-1:0]       s_axis_tdata,
    // result out
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // p_w, p_x, p_y, p_z
    output logic      [4*qmr_pkg::DATA_W-1:0]       m_axis_tdata,
    // renormalised, zero_norm
    output logic      [1:0]                         m_axis_tuser
);
    import qmr_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int IW    = F + 2;
    localparam int SW    = 2 * F + 4;
    localparam int MW    = F + 1;
    localparam int QW    = 2 * F + 2;
    localparam int NW    = 2 * F + 4;
    localparam int RW    = NW / 2 + 1;
    localparam int NUMW  = 2 * F + 2;
    localparam int LS    = NW / 2 + 1;
    localparam int LD    = NUMW + 1;
    localparam int DL    = LS + LD;
    localparam int DLW   = 2 + 4 + 4 * MW;
    localparam int NSTG  = 7 + DL + 1;
    localparam int SHIFT = 60 - 2 * F;

    localparam logic signed [DATA_W-1:0] LIM_IN = DATA_W'(1) << F;
    localparam logic [SW-1:0]            LIM_C  = (SW'(1) << (F + 1)) - SW'(1);
    localparam logic [SW-1:0]            HALF   = SW'(1) << (F - 1);
    localparam logic [NW-1:0]            ONE_N  = NW'(1) << (2 * F);
    localparam logic [NUMW-1:0]          LIM_Q  = NUMW'(1) << F;
    localparam logic [MW-1:0]            LIM_M  = MW'(1) << F;

    // configuration
    logic [TOL_W-1:0] tol_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (psel && penable && pwrite && pready && paddr[3] == REG_TOL)
            tol_reg <= pwdata[TOL_W-1:0];
    end

    assign prdata = (paddr[3] == REG_TOL) ? APB_DATA_W'(tol_reg) : '0;

    // pipeline control
    logic [NSTG-1:0] vld_reg;
    logic            en;

    assign en            = !vld_reg[NSTG-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], s_axis_tvalid};
    end

    // stage 0: saturated inputs
    logic signed [IW-1:0] a_reg [4];
    logic signed [IW-1:0] b_reg [4];

    function automatic logic signed [IW-1:0] sat_in(input logic signed [DATA_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        begin
            r = v;
            if (v > LIM_IN)
                r = LIM_IN;
            else if (v < -LIM_IN)
                r = -LIM_IN;
            return IW'(r);
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                a_reg[i] <= sat_in(s_axis_tdata[i*DATA_W +: DATA_W]);
                b_reg[i] <= sat_in(s_axis_tdata[(i+4)*DATA_W +: DATA_W]);
            end
        end
    end

    // stage 1: partial products
    logic signed [SW-1:0] prod_reg [4][4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                    prod_reg[i][j] <= SW'(a_reg[i]) * SW'(b_reg[j]);
        end
    end

    // stage 2: four-term sums
    logic signed [SW-1:0] sum_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg[0] <= prod_reg[0][0] - prod_reg[1][1] - prod_reg[2][2] - prod_reg[3][3];
            sum_reg[1] <= prod_reg[0][1] + prod_reg[1][0] + prod_reg[2][3] - prod_reg[3][2];
            sum_reg[2] <= prod_reg[0][2] + prod_reg[2][0] + prod_reg[3][1] - prod_reg[1][3];
            sum_reg[3] <= prod_reg[0][3] + prod_reg[3][0] + prod_reg[1][2] - prod_reg[2][1];
        end
    end

    // stage 3: round half away from zero, saturate
    logic [MW-1:0] cmag3_reg [4];
    logic          cneg3_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                logic [SW-1:0] mag;
                logic [SW-1:0] rnd;
                mag = sum_reg[i][SW-1] ? SW'(-sum_reg[i]) : SW'(sum_reg[i]);
                rnd = (mag + HALF) >> F;
                if (rnd > LIM_C)
                    rnd = LIM_C;
                cmag3_reg[i] <= rnd[MW-1:0];
                cneg3_reg[i] <= sum_reg[i][SW-1];
            end
        end
    end

    // stage 4: squares
    logic [QW-1:0] sq_reg    [4];
    logic [MW-1:0] cmag4_reg [4];
    logic          cneg4_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i]    <= QW'(cmag3_reg[i]) * QW'(cmag3_reg[i]);
                cmag4_reg[i] <= cmag3_reg[i];
                cneg4_reg[i] <= cneg3_reg[i];
            end
        end
    end

    // stage 5: squared norm
    logic [NW-1:0] n5_reg;
    logic [MW-1:0] cmag5_reg [4];
    logic          cneg5_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n5_reg <= NW'(sq_reg[0]) + NW'(sq_reg[1]) + NW'(sq_reg[2]) + NW'(sq_reg[3]);
            for (int i = 0; i < 4; i++)
            begin
                cmag5_reg[i] <= cmag4_reg[i];
                cneg5_reg[i] <= cneg4_reg[i];
            end
        end
    end

    // stage 6: tolerance check
    logic [NW-1:0]  n6_reg;
    logic [DLW-1:0] pack6_reg;
    logic [NW-1:0]  dev;
    logic [TOL_W-1:0] thr;
    logic [DLW-1:0] pack5;

    assign dev = (n5_reg >= ONE_N) ? (n5_reg - ONE_N) : (ONE_N - n5_reg);
    assign thr = tol_reg >> SHIFT;

    always_comb
    begin
        pack5 = '0;
        pack5[0] = (n5_reg == '0);
        pack5[1] = (n5_reg != '0) && (64'(dev) > 64'(thr));
        for (int i = 0; i < 4; i++)
        begin
            pack5[2+i] = cneg5_reg[i];
            pack5[6+i*MW +: MW] = cmag5_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n6_reg    <= n5_reg;
            pack6_reg <= pack5;
        end
    end

    // norm
    logic [RW-1:0] root;

    qmr_sqrt #(
        .NW (NW)
    ) u_sqrt (
        .clk      (clk),
        .en       (en),
        .n_in     (n6_reg),
        .root_out (root)
    );

    // side data delay line
    logic [DLW-1:0] dly_reg [DL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= pack6_reg;
            for (int k = 1; k < DL; k++)
                dly_reg[k] <= dly_reg[k-1];
        end
    end

    // dividers
    logic [NUMW-1:0] quo [4];

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            logic [NUMW-1:0] num;
            assign num = (NUMW'(dly_reg[LS-1][6+g*MW +: MW]) << F) + NUMW'(root >> 1);

            qmr_div #(
                .NUMW (NUMW),
                .DENW (RW)
            ) u_div (
                .clk (clk),
                .en  (en),
                .num (num),
                .den (root),
                .quo (quo[g])
            );
        end
    endgenerate

    // output register
    logic [4*DATA_W-1:0] tdata_reg;
    logic [1:0]          tuser_reg;
    logic [DLW-1:0]      side;

    assign side = dly_reg[DL-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                logic [MW-1:0] m;
                logic [NUMW-1:0] q;
                q = (quo[i] > LIM_Q) ? LIM_Q : quo[i];
                m = side[6+i*MW +: MW];
                if (side[1])
                    m = q[MW-1:0];
                else if (m > LIM_M)
                    m = LIM_M;
                tdata_reg[i*DATA_W +: DATA_W] <= side[2+i] ? -DATA_W'(m) : DATA_W'(m);
            end
            tuser_reg <= {side[0], side[1]};
        end
    end

    assign m_axis_tdata = tdata_reg;
    assign m_axis_tuser = tuser_reg;

    // checks
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("renormalised and zero_norm both set");

    a_zero_norm_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0))
        else $error("zero norm result with nonzero data");

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request accepted while output stalled");

endmodule

`default_nettype wire
